/* rtl/core/rgbled_pkg.sv */
// ----------------------------------------------------------------------------
// rgbled_pkg
// Shared types and constants of the RGB LED strip frame transmitter.
// ----------------------------------------------------------------------------
package rgbled_pkg;

  // Default pixel store depth
  localparam int unsigned MaxPixelsDef = 256;

  // Bits sent per pixel
  localparam logic [4:0] BitsPerPixel = 5'd24;

  // Register reset values
  localparam logic [7:0]  ZeroHighRst  = 8'd4;
  localparam logic [7:0]  OneHighRst   = 8'd11;
  localparam logic [9:0]  BitPeriodRst = 10'd20;
  localparam logic [15:0] LatchRst     = 16'd1000;
  localparam logic [8:0]  PixCountRst  = 9'd256;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_START = 2'd2,
    KIND_TICK  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SEND  = 2'd1,
    PH_LATCH = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    CFG_ZERO_HIGH  = 3'd0,
    CFG_ONE_HIGH   = 3'd1,
    CFG_BIT_PERIOD = 3'd2,
    CFG_LATCH      = 3'd3,
    CFG_PIX_COUNT  = 3'd4
  } cfg_idx_e;

  // Packed R,G,B to wire order G,R,B
  function automatic logic [23:0] to_grb(input logic [23:0] c);
    return {c[15:8], c[23:16], c[7:0]};
  endfunction

endpackage

/* rtl/core/rgb_led_strip_frame_transmitter.sv */
// ----------------------------------------------------------------------------
// rgb_led_strip_frame_transmitter
// Pixel store and one-wire serializer for an addressable RGB LED strip.
// ----------------------------------------------------------------------------
// A new item is taken on every clock edge where start is high; busy stays low,
// so the block sustains one item per cycle. Each item gives exactly one result,
// strobed on res_valid_o; on its way the item is captured in
// an input stage (the pixel store is read in the accept cycle, data registered),
// then processed against the frame state and written to the result register.
// The receiver cannot stall, so results must be taken as they appear. A tick
// item advances the line waveform by one base clock: while a frame is active
// the line follows the configured high widths inside a fixed bit period,
// pixels go out as green, red, blue, MSB first, and after the last bit the line
// stays low for the latch time, ending in a frame_done pulse. Write and start
// items arriving while a frame is active are dropped and flagged as ignored;
// reads are served at any time. Every pixel sent by a frame must have been
// written first. Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// and should only be changed while the block is idle.
// ----------------------------------------------------------------------------
module rgb_led_strip_frame_transmitter #(
  parameter int unsigned MAX_PIXELS = rgbled_pkg::MaxPixelsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  pixel_index_i,
  input  logic [23:0] color_i,
  // results
  output logic        res_valid_o,
  output logic        line_level_o,
  output logic        busy_res_o,
  output logic [23:0] read_color_o,
  output logic        frame_done_o,
  output logic        ignored_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  // Usable store depth: pixel indexes and frame lengths never exceed 256.
  localparam int unsigned Depth = (MAX_PIXELS < 256) ? MAX_PIXELS : 256;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned MemWords = 2 ** AddrW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  zero_high_q;
  logic [7:0]  one_high_q;
  logic [9:0]  bit_period_q;
  logic [15:0] latch_q;
  logic [8:0]  pix_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_high_q  <= rgbled_pkg::ZeroHighRst;
      one_high_q   <= rgbled_pkg::OneHighRst;
      bit_period_q <= rgbled_pkg::BitPeriodRst;
      latch_q      <= rgbled_pkg::LatchRst;
      pix_count_q  <= rgbled_pkg::PixCountRst;
    end else if (cfg_we_i) begin
      case (rgbled_pkg::cfg_idx_e'(cfg_idx_i))
        rgbled_pkg::CFG_ZERO_HIGH:  zero_high_q  <= cfg_wdata_i[7:0];
        rgbled_pkg::CFG_ONE_HIGH:   one_high_q   <= cfg_wdata_i[7:0];
        rgbled_pkg::CFG_BIT_PERIOD: bit_period_q <= cfg_wdata_i[9:0];
        rgbled_pkg::CFG_LATCH:      latch_q      <= cfg_wdata_i;
        rgbled_pkg::CFG_PIX_COUNT:  pix_count_q  <= cfg_wdata_i[8:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // Effective frame length: zero acts as one, clipped to the store depth.
  logic [8:0] frame_len;
  always_comb begin
    if (pix_count_q > 9'(Depth)) begin
      frame_len = 9'(Depth);
    end else if (pix_count_q == 9'd0) begin
      frame_len = 9'd1;
    end else begin
      frame_len = pix_count_q;
    end
  end

  // Always ready: one item per cycle.
  assign busy = 1'b0;

  logic accept;
  assign accept = start & ~busy;

  // --------------------------------------------------------------------------
  // Input stage
  // --------------------------------------------------------------------------
  logic                  s1_vld_q;
  rgbled_pkg::kind_e     s1_kind_q;
  logic [AddrW-1:0]      s1_addr_q;
  logic                  s1_idx_ok_q;
  logic [23:0]           s1_color_q;

  logic idx_ok_in;
  assign idx_ok_in = (32'(pixel_index_i) < MAX_PIXELS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_kind_q   <= rgbled_pkg::kind_e'(kind_i);
      s1_addr_q   <= pixel_index_i[AddrW-1:0];
      s1_idx_ok_q <= idx_ok_in;
      s1_color_q  <= color_i;
    end
  end

  // --------------------------------------------------------------------------
  // Frame state
  // --------------------------------------------------------------------------
  rgbled_pkg::phase_e phase_q, phase_d;
  logic [7:0]         ptr_q, ptr_d;
  logic [23:0]        shift_q, shift_d;
  logic [4:0]         bit_cnt_q, bit_cnt_d;
  logic [15:0]        tick_q, tick_d;
  logic               line_q, line_d;
  logic               done_d;
  logic               ign_d;

  // --------------------------------------------------------------------------
  // Pixel store: write from the input stage, two registered read ports.
  // Port A serves read items, port B keeps the next pixel to send on hand.
  // Both bypass the write of the same cycle.
  // --------------------------------------------------------------------------
  logic [23:0]      mem [MemWords];
  logic             mem_we;
  logic [AddrW-1:0] rda_addr;
  logic [AddrW-1:0] rdb_addr;
  logic [23:0]      rda_q;
  logic [23:0]      rdb_q;
  logic [7:0]       ptr_next_d;

  assign mem_we = s1_vld_q && (s1_kind_q == rgbled_pkg::KIND_WRITE) &&
                  (phase_q == rgbled_pkg::PH_IDLE) && s1_idx_ok_q;
  assign rda_addr = pixel_index_i[AddrW-1:0];
  // Idle: pixel 0 for the next frame start; sending: the pixel after ptr.
  assign ptr_next_d = ptr_d + 8'd1;
  assign rdb_addr = (phase_d == rgbled_pkg::PH_IDLE) ? '0 : ptr_next_d[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[s1_addr_q] <= s1_color_q;
    end
    rda_q <= (mem_we && (s1_addr_q == rda_addr)) ? s1_color_q : mem[rda_addr];
    rdb_q <= (mem_we && (s1_addr_q == rdb_addr)) ? s1_color_q : mem[rdb_addr];
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  logic [15:0] tick_inc;
  logic [4:0]  bit_inc;
  logic [8:0]  ptr_inc;
  logic [7:0]  high_w;
  logic        busy_now;

  assign tick_inc = tick_q + 16'd1;
  assign bit_inc  = bit_cnt_q + 5'd1;
  assign ptr_inc  = {1'b0, ptr_q} + 9'd1;
  assign high_w   = shift_q[23] ? one_high_q : zero_high_q;
  assign busy_now = (phase_q != rgbled_pkg::PH_IDLE);

  always_comb begin
    phase_d   = phase_q;
    ptr_d     = ptr_q;
    shift_d   = shift_q;
    bit_cnt_d = bit_cnt_q;
    tick_d    = tick_q;
    line_d    = line_q;
    done_d    = 1'b0;
    ign_d     = 1'b0;
    if (s1_vld_q) begin
      case (s1_kind_q)
        rgbled_pkg::KIND_WRITE: begin
          ign_d = busy_now;
        end
        rgbled_pkg::KIND_START: begin
          if (busy_now) begin
            ign_d = 1'b1;
          end else begin
            ptr_d     = 8'd0;
            shift_d   = rgbled_pkg::to_grb(rdb_q);
            bit_cnt_d = 5'd0;
            tick_d    = 16'd0;
            phase_d   = rgbled_pkg::PH_SEND;
          end
        end
        rgbled_pkg::KIND_TICK: begin
          case (phase_q)
            rgbled_pkg::PH_SEND: begin
              line_d = (tick_q < {8'd0, high_w});
              tick_d = tick_inc;
              if (tick_inc >= {6'd0, bit_period_q}) begin
                tick_d    = 16'd0;
                shift_d   = {shift_q[22:0], 1'b0};
                bit_cnt_d = bit_inc;
                if (bit_inc >= rgbled_pkg::BitsPerPixel) begin
                  bit_cnt_d = 5'd0;
                  if (ptr_inc >= frame_len) begin
                    phase_d = rgbled_pkg::PH_LATCH;
                  end else begin
                    ptr_d   = ptr_inc[7:0];
                    shift_d = rgbled_pkg::to_grb(rdb_q);
                  end
                end
              end
            end
            rgbled_pkg::PH_LATCH: begin
              line_d = 1'b0;
              tick_d = tick_inc;
              if (tick_inc >= latch_q) begin
                tick_d  = 16'd0;
                phase_d = rgbled_pkg::PH_IDLE;
                done_d  = 1'b1;
              end
            end
            default: begin
              line_d = 1'b0;
            end
          endcase
        end
        default: ;  // reads leave the state alone
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= rgbled_pkg::PH_IDLE;
      ptr_q     <= 8'd0;
      shift_q   <= 24'd0;
      bit_cnt_q <= 5'd0;
      tick_q    <= 16'd0;
      line_q    <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      ptr_q     <= ptr_d;
      shift_q   <= shift_d;
      bit_cnt_q <= bit_cnt_d;
      tick_q    <= tick_d;
      line_q    <= line_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [23:0] read_col_d;

  always_comb begin
    read_col_d = 24'd0;
    if (s1_vld_q && (s1_kind_q == rgbled_pkg::KIND_READ) && s1_idx_ok_q) begin
      read_col_d = rda_q;
    end
  end

  logic        res_valid_q;
  logic        res_line_q;
  logic        res_busy_q;
  logic [23:0] res_color_q;
  logic        res_done_q;
  logic        res_ign_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      res_line_q  <= line_d;
      res_busy_q  <= (phase_d != rgbled_pkg::PH_IDLE);
      res_color_q <= read_col_d;
      res_done_q  <= done_d;
      res_ign_q   <= ign_d;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign line_level_o = res_line_q;
  assign busy_res_o   = res_busy_q;
  assign read_color_o = res_color_q;
  assign frame_done_o = res_done_q;
  assign ignored_o    = res_ign_q;

`ifndef SYNTHESIS
  // A frame end leaves the block idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && frame_done_o |-> !busy_res_o)
    else $error("frame_done with busy_res set");

  // Drops only happen when a frame was already running.
  a_ign_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_ign_q |-> $past(phase_q != rgbled_pkg::PH_IDLE))
    else $error("item ignored while idle");

  // The bit counter never reaches a full pixel.
  a_bit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_cnt_q < rgbled_pkg::BitsPerPixel)
    else $error("bit counter out of range");

  // The line only goes high inside a frame.
  a_line_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && line_level_o |-> busy_res_o)
    else $error("line high while idle");
`endif

endmodule
